[rtl/edf_pkg.sv]
`timescale 1ns / 1ps
package edf_pkg;

   localparam int MAX_ENTRIES = 32;
   localparam int IDX_W       = $clog2(MAX_ENTRIES);
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
   localparam int ID_W        = 16;
   localparam int TIME_W      = 32;
   localparam int TOTAL_W     = 32;
   localparam int LIMIT_W     = 6;
   localparam int ENTRY_W     = ID_W + TIME_W;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd4;

   // command codes
   localparam logic [1:0] CMD_ADD    = 2'd0;
   localparam logic [1:0] CMD_TICK   = 2'd1;
   localparam logic [1:0] CMD_FINISH = 2'd2;

   // result kinds
   localparam logic [2:0] KIND_ADDED     = 3'd0;
   localparam logic [2:0] KIND_FULL      = 3'd1;
   localparam logic [2:0] KIND_FINISHED  = 3'd2;
   localparam logic [2:0] KIND_PREEMPTED = 3'd3;
   localparam logic [2:0] KIND_ACTIVE    = 3'd4;
   localparam logic [2:0] KIND_EMPTY     = 3'd5;

   typedef struct packed {
      logic [1:0]        command;
      logic [ID_W-1:0]   request_id;
      logic [TIME_W-1:0] deadline;
      logic [TIME_W-1:0] now_time;
   } req_type;

   typedef struct packed {
      logic [2:0]         kind;
      logic [ID_W-1:0]    result_id;
      logic               last;
      logic [TOTAL_W-1:0] violation_total;
      logic [TOTAL_W-1:0] preemption_total;
   } rsp_type;

   // one result from the sequencer, before the output register
   typedef struct packed {
      logic              valid;
      logic [2:0]        kind;
      logic [ID_W-1:0]   id;
      logic              last;
   } emit_type;

endpackage

[rtl/edf_batch_scheduler.sv]
`timescale 1ns / 1ps
// add and finish: an id lookup over every slot, then an apply step that gives the one result
// tick: late scan, one selection pass per active id (plus a closing empty pass below the limit),
//   preemption count, preempt scan, then the active ids in order or one empty result if none
// one item at a time; busy drops as the last result enters the output register
// results cannot be stalled; all table reads share the one read port
// synchronous reset empties the table, clears both totals and sets the batch limit to 4
module edf_batch_scheduler (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  edf_pkg::req_type            req_item,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [edf_pkg::LIMIT_W-1:0] csr_data,
   output logic                        rsp_valid,
   output edf_pkg::rsp_type            rsp_item
);
   import edf_pkg::*;

   logic [LIMIT_W-1:0] limit_ff;
   logic [IDX_W-1:0]   rd_addr, wr_addr;
   logic [ENTRY_W-1:0] rd_data, wr_data;
   logic               wr_en;
   emit_type           emit;
   logic [TOTAL_W-1:0] late_total, preempt_total;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   assign csr_ready = !busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   edf_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_ENTRIES)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   edf_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_item      (req_item),
      .limit         (limit_ff),
      .rd_data       (rd_data),
      .rd_addr       (rd_addr),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .busy          (busy),
      .emit          (emit),
      .late_total    (late_total),
      .preempt_total (preempt_total)
   );

   // batch limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         limit_ff <= csr_data;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= emit.valid;
      end
      rsp_ff.kind             <= emit.kind;
      rsp_ff.result_id        <= emit.id;
      rsp_ff.last             <= emit.last;
      rsp_ff.violation_total  <= late_total;
      rsp_ff.preemption_total <= preempt_total;
   end
endmodule

[rtl/edf_ram.sv]
`timescale 1ns / 1ps
module edf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

[rtl/edf_ctrl.sv]
`timescale 1ns / 1ps
module edf_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  edf_pkg::req_type              req_item,
   input  logic [edf_pkg::LIMIT_W-1:0]   limit,
   input  logic [edf_pkg::ENTRY_W-1:0]   rd_data,
   output logic [edf_pkg::IDX_W-1:0]     rd_addr,
   output logic                          wr_en,
   output logic [edf_pkg::IDX_W-1:0]     wr_addr,
   output logic [edf_pkg::ENTRY_W-1:0]   wr_data,
   output logic                          busy,
   output edf_pkg::emit_type             emit,
   output logic [edf_pkg::TOTAL_W-1:0]   late_total,
   output logic [edf_pkg::TOTAL_W-1:0]   preempt_total
);
   import edf_pkg::*;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_FIND  = 4'd1;
   localparam logic [3:0] ST_APPLY = 4'd2;
   localparam logic [3:0] ST_LATE  = 4'd3;
   localparam logic [3:0] ST_SEL   = 4'd4;
   localparam logic [3:0] ST_PCNT  = 4'd5;
   localparam logic [3:0] ST_PEMIT = 4'd6;
   localparam logic [3:0] ST_AEMIT = 4'd7;
   localparam logic [3:0] ST_EMPTY = 4'd8;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);

   logic [3:0]             state_ff, state_in;
   req_type                req_ff, req_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic                   ph_ff, ph_in;
   logic [MAX_ENTRIES-1:0] valid_ff, valid_in;
   logic [MAX_ENTRIES-1:0] late_ff, late_in;
   logic [MAX_ENTRIES-1:0] active_ff, active_in;
   logic [MAX_ENTRIES-1:0] next_ff, next_in;
   logic [IDX_W-1:0]       sel_ff [MAX_ENTRIES];
   logic                   sel_we;
   logic [CNT_W-1:0]       nact_ff, nact_in;
   logic [IDX_W-1:0]       k_ff, k_in;
   logic                   found_ff, found_in;
   logic [IDX_W-1:0]       slot_ff, slot_in;
   logic [TIME_W-1:0]      best_dl_ff, best_dl_in;
   logic [TOTAL_W-1:0]     late_cnt_ff, late_cnt_in;
   logic [TOTAL_W-1:0]     pre_cnt_ff, pre_cnt_in;

   logic [ID_W-1:0]   rd_id;
   logic [TIME_W-1:0] rd_dl;
   logic              take;
   logic [IDX_W-1:0]  pick;
   logic              free_any;
   logic [IDX_W-1:0]  free_slot;

   assign rd_id = rd_data[ENTRY_W-1 -: ID_W];
   assign rd_dl = rd_data[TIME_W-1:0];
   assign busy  = (state_ff != ST_IDLE);
   assign late_total    = late_cnt_ff;
   assign preempt_total = pre_cnt_ff;

   // lowest free slot
   always_comb begin
      free_any  = 1'b0;
      free_slot = '0;
      for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_any  = 1'b1;
            free_slot = IDX_W'(i);
         end
      end
   end

   // earliest candidate so far; strict compare keeps the lower slot on ties
   assign take = valid_ff[idx_ff] && !next_ff[idx_ff] && (!found_ff || rd_dl < best_dl_ff);
   assign pick = take ? idx_ff : slot_ff;

   // sequencer
   always_comb begin
      state_in    = state_ff;
      req_in      = req_ff;
      idx_in      = idx_ff;
      ph_in       = ph_ff;
      valid_in    = valid_ff;
      late_in     = late_ff;
      active_in   = active_ff;
      next_in     = next_ff;
      nact_in     = nact_ff;
      k_in        = k_ff;
      found_in    = found_ff;
      slot_in     = slot_ff;
      best_dl_in  = best_dl_ff;
      late_cnt_in = late_cnt_ff;
      pre_cnt_in  = pre_cnt_ff;
      sel_we      = 1'b0;
      rd_addr     = idx_ff;
      wr_en       = 1'b0;
      wr_addr     = slot_ff;
      wr_data     = {req_ff.request_id, req_ff.deadline};
      emit        = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in   = req_item;
               idx_in   = '0;
               ph_in    = 1'b0;
               found_in = 1'b0;
               nact_in  = '0;
               next_in  = '0;
               if (req_item.command == CMD_TICK) begin
                  state_in = ST_LATE;
               end else if (req_item.command == CMD_ADD ||
                            req_item.command == CMD_FINISH) begin
                  state_in = ST_FIND;
               end
            end
         end
         // look up the id, one slot after another over the whole table
         ST_FIND: begin
            ph_in = ~ph_ff;
            if (ph_ff) begin
               if (!found_ff && valid_ff[idx_ff] && rd_id == req_ff.request_id) begin
                  found_in = 1'b1;
                  slot_in  = idx_ff;
               end
               idx_in = idx_ff + 1'b1;
               if (idx_ff == LAST_IDX) begin
                  state_in = ST_APPLY;
               end
            end
         end
         ST_APPLY: begin
            state_in  = ST_IDLE;
            emit.valid = 1'b1;
            emit.last  = 1'b1;
            emit.id    = req_ff.request_id;
            if (req_ff.command == CMD_FINISH) begin
               emit.kind = KIND_FINISHED;
               if (found_ff) begin
                  valid_in[slot_ff]  = 1'b0;
                  late_in[slot_ff]   = 1'b0;
                  active_in[slot_ff] = 1'b0;
               end
            end else if (found_ff) begin
               emit.kind = KIND_ADDED;
               wr_en     = 1'b1;
            end else if (free_any) begin
               emit.kind = KIND_ADDED;
               wr_en     = 1'b1;
               wr_addr   = free_slot;
               valid_in[free_slot]  = 1'b1;
               late_in[free_slot]   = 1'b0;
               active_in[free_slot] = 1'b0;
            end else begin
               emit.kind = KIND_FULL;
            end
         end
         // mark and count newly late entries
         ST_LATE: begin
            ph_in = ~ph_ff;
            if (ph_ff) begin
               if (valid_ff[idx_ff] && rd_dl < req_ff.now_time && !late_ff[idx_ff]) begin
                  late_in[idx_ff] = 1'b1;
                  if (late_cnt_ff != '1) begin
                     late_cnt_in = late_cnt_ff + 1'b1;
                  end
               end
               idx_in = idx_ff + 1'b1;
               if (idx_ff == LAST_IDX) begin
                  state_in = (limit == '0) ? ST_PCNT : ST_SEL;
               end
            end
         end
         // one minimum search pass per active slot
         ST_SEL: begin
            ph_in = ~ph_ff;
            if (ph_ff) begin
               if (take) begin
                  found_in   = 1'b1;
                  slot_in    = idx_ff;
                  best_dl_in = rd_dl;
               end
               idx_in = idx_ff + 1'b1;
               if (idx_ff == LAST_IDX) begin
                  found_in = 1'b0;
                  if (take || found_ff) begin
                     next_in[pick] = 1'b1;
                     sel_we        = 1'b1;
                     nact_in       = nact_ff + 1'b1;
                     if (32'(nact_ff) + 32'd1 >= 32'(limit)) begin
                        state_in = ST_PCNT;
                     end
                  end else begin
                     state_in = ST_PCNT;
                  end
               end
            end
         end
         // count preemptions before any result leaves
         ST_PCNT: begin
            if (active_ff[idx_ff] && !next_ff[idx_ff] && pre_cnt_ff != '1) begin
               pre_cnt_in = pre_cnt_ff + 1'b1;
            end
            idx_in = idx_ff + 1'b1;
            ph_in  = 1'b0;
            if (idx_ff == LAST_IDX) begin
               state_in = ST_PEMIT;
            end
         end
         // preempted ids in slot order
         ST_PEMIT: begin
            ph_in = ~ph_ff;
            if (ph_ff) begin
               if (active_ff[idx_ff] && !next_ff[idx_ff]) begin
                  emit.valid = 1'b1;
                  emit.kind  = KIND_PREEMPTED;
                  emit.id    = rd_id;
               end
               idx_in = idx_ff + 1'b1;
               if (idx_ff == LAST_IDX) begin
                  active_in = next_ff;
                  k_in      = '0;
                  state_in  = (nact_ff == '0) ? ST_EMPTY : ST_AEMIT;
               end
            end
         end
         // active ids in deadline order
         ST_AEMIT: begin
            rd_addr = sel_ff[k_ff];
            ph_in   = ~ph_ff;
            if (ph_ff) begin
               emit.valid = 1'b1;
               emit.kind  = KIND_ACTIVE;
               emit.id    = rd_id;
               k_in       = k_ff + 1'b1;
               if (32'(k_ff) + 32'd1 == 32'(nact_ff)) begin
                  emit.last = 1'b1;
                  state_in  = ST_IDLE;
               end
            end
         end
         ST_EMPTY: begin
            emit.valid = 1'b1;
            emit.kind  = KIND_EMPTY;
            emit.last  = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         valid_ff    <= '0;
         late_ff     <= '0;
         active_ff   <= '0;
         late_cnt_ff <= '0;
         pre_cnt_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         valid_ff    <= valid_in;
         late_ff     <= late_in;
         active_ff   <= active_in;
         late_cnt_ff <= late_cnt_in;
         pre_cnt_ff  <= pre_cnt_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      idx_ff     <= idx_in;
      ph_ff      <= ph_in;
      next_ff    <= next_in;
      nact_ff    <= nact_in;
      k_ff       <= k_in;
      found_ff   <= found_in;
      slot_ff    <= slot_in;
      best_dl_ff <= best_dl_in;
      if (sel_we) begin
         sel_ff[nact_ff[IDX_W-1:0]] <= pick;
      end
   end

`ifndef SYNTHESIS
   a_emit_busy: assert property (@(posedge clock) disable iff (reset)
      emit.valid |-> state_ff != ST_IDLE)
      else $error("result outside an item");
   a_nact_limit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_AEMIT |-> 32'(nact_ff) <= 32'(limit))
      else $error("active set above limit");
   a_late_mono: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> late_cnt_ff >= $past(late_cnt_ff))
      else $error("violation count went down");
   a_late_valid: assert property (@(posedge clock) disable iff (reset)
      (late_ff & ~valid_ff) == '0)
      else $error("late mark on empty slot");
`endif
endmodule
